// File: sv/mslu_pkg.sv
// Shared constants, opcodes and status types for the multi-speed layer looper.
// Used by the controller, the datapath and the top level; depends on nothing.
package mslu_pkg;

  localparam int LOOP_MAX_DEF    = 262144;
  localparam int LAYER_COUNT_DEF = 4;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 21;
  localparam int CFG_W      = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int GAIN_W     = 17;
  localparam int STORE_W    = 24;
  localparam int WET_W      = 32;
  localparam int SV_W       = 32;
  localparam int VV_W       = 34;
  localparam int CNT_W      = 5;
  localparam int UNITY      = 65536;
  localparam int LEN_RESET  = 96000;
  localparam int VOL_RESET  = 32768;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEED_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_TARGET = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_REM, OP_SETP, OP_WRD, OP_WWR,
    OP_RDA, OP_RDB, OP_LACC, OP_M0, OP_M1, OP_FIN
  } op_t;

  typedef struct packed {
    logic rem_done;
    logic clr_last;
    logic lay_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/mslu_ctrl.sv
// Sequencer of the layer looper: walks each word through its datapath steps.
// Depends on mslu_pkg for opcodes and the status struct.
module mslu_ctrl import mslu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  dp_status_t st,
  output logic       in_stall,
  output op_t        op
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_SPAN  = 11'b00000000100,
    S_WIDX  = 11'b00000001000,
    S_WWR   = 11'b00000010000,
    S_LIDX  = 11'b00000100000,
    S_RDB   = 11'b00001000000,
    S_LACC  = 11'b00010000000,
    S_M0    = 11'b00100000000,
    S_M1    = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        op = OP_CLR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd) begin
            state_nxt = S_CLEAR;
          end else begin
            op        = OP_LOAD;
            state_nxt = S_SPAN;
          end
        end
      end
      S_SPAN: begin
        if (st.rem_done) begin
          op        = OP_SETP;
          state_nxt = S_WIDX;
        end else begin
          op = OP_REM;
        end
      end
      S_WIDX: begin
        if (st.rem_done) begin
          op        = OP_WRD;
          state_nxt = S_WWR;
        end else begin
          op = OP_REM;
        end
      end
      S_WWR: begin
        op        = OP_WWR;
        state_nxt = S_LIDX;
      end
      S_LIDX: begin
        if (st.rem_done) begin
          op        = OP_RDA;
          state_nxt = S_RDB;
        end else begin
          op = OP_REM;
        end
      end
      S_RDB: begin
        op        = OP_RDB;
        state_nxt = S_LACC;
      end
      S_LACC: begin
        op        = OP_LACC;
        state_nxt = st.lay_last ? S_M0 : S_LIDX;
      end
      S_M0: begin
        op        = OP_M0;
        state_nxt = S_M1;
      end
      S_M1: begin
        op        = OP_M1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          op        = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sv/mslu_dp.sv
// Datapath of the layer looper: settings, remainder unit, loop store, mixer.
// Depends on mslu_pkg; driven one step a cycle by mslu_ctrl unless the output is held.
module mslu_dp import mslu_pkg::*; #(
  parameter int LOOP_MAX    = LOOP_MAX_DEF,
  parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  op_t                        op,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic [POS_W-1:0]           in_cycle_position,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output dp_status_t                 st
);

  localparam int ADDR_W  = $clog2(LOOP_MAX);
  localparam int LEN_W   = $clog2(LOOP_MAX + 1);
  localparam int SH      = LAYER_COUNT - 1;
  localparam int R_W     = LEN_W + SH + 1;
  localparam int LAY_W   = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int FW      = (SH > 0) ? SH : 1;
  localparam int DIFF_W  = STORE_W + 1;
  localparam int PROD_W  = DIFF_W + FW + 1;
  localparam int PP_W    = WET_W + 18;
  localparam int TOT_W   = PP_W + 17;
  localparam int Y_W     = TOT_W - 30 + 1;

  // Settings.
  logic [CFG_W-1:0]  len_cfg_r;
  logic [GAIN_W-1:0] gain_r, vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= CFG_W'(LEN_RESET);
      gain_r    <= '0;
      vol_r     <= GAIN_W'(VOL_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOP_LENGTH:   len_cfg_r <= cfg_wdata;
        CFG_FEED_GAIN:     gain_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_VOLUME_TARGET: vol_r     <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0]  len_eff;
  logic [R_W-1:0]    span;
  logic [GAIN_W-1:0] g, vt, ug;

  always_comb begin
    if (len_cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(len_cfg_r) > 32'(LOOP_MAX)) begin
      len_eff = LEN_W'(LOOP_MAX);
    end else begin
      len_eff = LEN_W'(len_cfg_r);
    end
  end

  assign span = R_W'(len_eff) << SH;
  assign g    = (gain_r > GAIN_W'(UNITY)) ? GAIN_W'(UNITY) : gain_r;
  assign vt   = (vol_r > GAIN_W'(UNITY)) ? GAIN_W'(UNITY) : vol_r;
  assign ug   = GAIN_W'(UNITY) - g;

  // Restoring remainder unit, one quotient bit per step.
  logic [R_W-1:0]   rem_r, mod_r;
  logic [POS_W-1:0] remx_r;
  logic [CNT_W-1:0] remcnt_r;
  logic [R_W-1:0]   rem_t;
  logic [R_W-1:0]   rem_step;

  assign rem_t    = {rem_r[R_W-2:0], remx_r[POS_W-1]};
  assign rem_step = (rem_t >= mod_r) ? rem_t - mod_r : rem_t;

  logic [POS_W+R_W-1:0] rem_ext;
  logic [POS_W-1:0]     rem_p;
  assign rem_ext = {{POS_W{1'b0}}, rem_r};
  assign rem_p   = rem_ext[POS_W-1:0];

  logic [POS_W-1:0] p_r;
  logic [LAY_W-1:0] lay_r;

  // Start of an index reduction: q = p >> layer is below length << SH, so only the
  // low SH bits of q still need a quotient step.
  logic [POS_W-1:0]     ls_p, ls_q;
  logic [LAY_W-1:0]     ls_lay;
  logic [POS_W+R_W-1:0] ls_hi;

  always_comb begin
    ls_p   = p_r;
    ls_lay = lay_r;
    if (op == OP_SETP) begin
      ls_p   = rem_p;
      ls_lay = '0;
    end else if (op == OP_LACC) begin
      ls_lay = LAY_W'(lay_r + 1'b1);
    end
  end

  assign ls_q  = ls_p >> ls_lay;
  assign ls_hi = {{R_W{1'b0}}, ls_q >> SH};

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      rem_r    <= '0;
      remx_r   <= in_cycle_position;
      remcnt_r <= CNT_W'(POS_W);
      mod_r    <= span;
    end else if (op == OP_REM) begin
      rem_r    <= rem_step;
      remx_r   <= {remx_r[POS_W-2:0], 1'b0};
      remcnt_r <= remcnt_r - 1'b1;
    end else if (op == OP_SETP || op == OP_WWR || op == OP_LACC) begin
      rem_r    <= ls_hi[R_W-1:0];
      remx_r   <= ls_q << (POS_W - SH);
      remcnt_r <= CNT_W'(SH);
      mod_r    <= R_W'(len_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lay_r <= '0;
    end else if (op == OP_SETP) begin
      lay_r <= '0;
    end else if (op == OP_LACC) begin
      lay_r <= LAY_W'(lay_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_SETP) p_r <= rem_p;
  end

  // Per-word products taken at accept time.
  logic signed [SAMPLE_W-1:0] s_r;
  logic signed [17:0]         sg_r;
  logic signed [WET_W-1:0]    wet_r;
  logic [SV_W-1:0]            sv_r;
  logic signed [33:0]         sprod, dprod;

  assign sprod = in_sample_in * $signed({1'b0, g});
  assign dprod = in_sample_in * $signed({1'b0, ug});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (op == OP_LOAD) begin
      sv_r <= sv_r - (sv_r >> 10) + SV_W'({vt, 5'b0});
    end
  end

  // Loop store.
  logic [STORE_W-1:0] mem [LOOP_MAX];
  logic signed [STORE_W-1:0] rd_q_r, a_r;
  logic [ADDR_W-1:0]  clr_addr_r, i0_r, i1, mem_waddr, mem_raddr;
  logic [STORE_W-1:0] mem_wdata;
  logic               mem_we, mem_re;
  logic signed [STORE_W+1:0] wacc;
  logic [STORE_W-1:0] wsat;

  assign wacc = (STORE_W+2)'(rd_q_r) + (STORE_W+2)'(sg_r);
  assign wsat = (&wacc[STORE_W+1:STORE_W-1] || ~|wacc[STORE_W+1:STORE_W-1]) ?
                wacc[STORE_W-1:0] : (wacc[STORE_W+1] ? {1'b1, {(STORE_W-1){1'b0}}}
                                                    : {1'b0, {(STORE_W-1){1'b1}}});
  assign i1 = (32'(i0_r) + 32'd1 == 32'(len_eff)) ? '0 : ADDR_W'(i0_r + 1'b1);

  assign mem_we    = (op == OP_CLR) || (op == OP_WWR);
  assign mem_waddr = (op == OP_CLR) ? clr_addr_r : rem_r[ADDR_W-1:0];
  assign mem_wdata = (op == OP_CLR) ? '0 : wsat;
  assign mem_re    = (op == OP_WRD) || (op == OP_RDA) || (op == OP_RDB);
  assign mem_raddr = (op == OP_RDB) ? i1 : rem_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (op == OP_CLR) begin
      clr_addr_r <= st.clr_last ? '0 : ADDR_W'(clr_addr_r + 1'b1);
    end
  end

  // Layer interpolation: a + ((b - a) * frac) >> layer.
  logic [FW-1:0]              fmask, frac;
  logic signed [DIFF_W-1:0]   diff, lval;
  logic signed [PROD_W-1:0]   lprod, lsh;

  assign fmask = ~({FW{1'b1}} << lay_r);
  assign frac  = p_r[FW-1:0] & fmask;
  assign diff  = DIFF_W'(rd_q_r) - DIFF_W'(a_r);
  assign lprod = diff * $signed({1'b0, frac});
  assign lsh   = lprod >>> lay_r;
  assign lval  = DIFF_W'(a_r) + lsh[DIFF_W-1:0];

  // Volume and final mix.
  logic [VV_W-1:0]          vv_r;
  logic signed [PP_W-1:0]   pl_r, ph_r;
  logic [16:0]              vq;
  logic signed [TOT_W-1:0]  tot, tsh;
  logic signed [Y_W-1:0]    y;
  logic [SAMPLE_W-1:0]      ysat;

  assign vq  = sv_r[SV_W-1:15];
  assign tot = (TOT_W'(ph_r) <<< 17) + TOT_W'(pl_r);
  assign tsh = tot >>> 30;
  assign y   = Y_W'(s_r) + tsh[Y_W-1:0];
  assign ysat = (&y[Y_W-1:SAMPLE_W-1] || ~|y[Y_W-1:SAMPLE_W-1]) ? y[SAMPLE_W-1:0] :
                (y[Y_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        s_r   <= in_sample_in;
        sg_r  <= sprod[33:16];
        wet_r <= WET_W'($signed(dprod[33:16]));
      end
      OP_WRD:  vv_r  <= VV_W'(vq * vq);
      OP_RDA:  i0_r  <= rem_r[ADDR_W-1:0];
      OP_RDB:  a_r   <= rd_q_r;
      OP_LACC: wet_r <= wet_r + WET_W'(lval);
      OP_M0:   pl_r  <= wet_r * $signed({1'b0, vv_r[16:0]});
      OP_M1:   ph_r  <= wet_r * $signed({1'b0, vv_r[VV_W-1:17]});
      default: ;
    endcase
  end

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_FIN) out_data_r <= ysat;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  assign st.rem_done = (remcnt_r == '0);
  assign st.clr_last = (clr_addr_r == ADDR_W'(LOOP_MAX - 1));
  assign st.lay_last = (lay_r == LAY_W'(LAYER_COUNT - 1));
  assign st.out_free = !out_valid_r || !out_stall;

endmodule

// File: sv/multi_speed_layer_looper_unit.sv
// Top level of the multi-speed layer looper: controller plus datapath.
// Depends on mslu_pkg, mslu_ctrl and mslu_dp.
//
//   channel  direction  handshake           payload
//   in       in         in_valid/in_stall   in_cmd, in_sample_in, in_cycle_position
//   out      out        out_valid/out_stall out_sample_out
//   cfg      in         cfg_we              cfg_index, cfg_wdata
//
// A sample word runs from its accept to its result through a 21-step remainder for the
// cycle position, then an index reduction, a store read and a store write for the feedback,
// then per layer an index reduction and two store reads on the one loop store, then the mix.
// The next word is taken only after the previous one has passed its final step.
// A clear word, and reset, run a clearing pass over all LOOP_MAX entries, one entry a
// cycle, with in_stall high. A finished word waits in the output register while the
// next input word is taken; out_stall holds back only the final step.
module multi_speed_layer_looper_unit import mslu_pkg::*; #(
  parameter int LOOP_MAX    = LOOP_MAX_DEF,
  parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic [POS_W-1:0]           in_cycle_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  op_t        op;
  dp_status_t st;

  mslu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .st       (st),
    .in_stall (in_stall),
    .op       (op)
  );

  mslu_dp #(
    .LOOP_MAX    (LOOP_MAX),
    .LAYER_COUNT (LAYER_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_sample_in      (in_sample_in),
    .in_cycle_position (in_cycle_position),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_sample_out    (out_sample_out),
    .st                (st)
  );

endmodule

// File: sv/mslu_checker.sv
// Port-level checks for the layer looper, bound to the top level.
// Depends on mslu_pkg for widths.
module mslu_checker import mslu_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SAMPLE_W-1:0] out_sample_out
);

  // A held result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("result word changed while stalled");

  // Every accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a word");

  // Reset starts the clearing pass.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // A new result only appears at the end of work on a word.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind multi_speed_layer_looper_unit mslu_checker u_mslu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out)
);
